@@ hw/rtl/sab_pkg.sv @@
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants for the scaled alpha blitter.
// ----------------------------------------------------------------------------
package sab_pkg;

  localparam int CANVAS_W_DEF = 320;
  localparam int CANVAS_H_DEF = 240;
  localparam int TEX_SIDE_DEF = 64;

  localparam int QW   = 7;   // quotient bits: texture coordinate
  localparam int NUMW = 19;  // offset * texture size
  localparam int TAW  = 14;  // texel address before range check
  localparam int CFGW = 13;  // widest register

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic       CMD_DRAW = 1'b1;
  localparam logic [7:0] ALPHA_FULL = 8'hff;
  localparam logic [7:0] ALPHA_NONE = 8'h00;
  localparam logic [31:0] OPAQUE = 32'hff00_0000;

  typedef enum logic [2:0] {
    REG_DEST_X      = 3'd0,
    REG_DEST_Y      = 3'd1,
    REG_DRAW_WIDTH  = 3'd2,
    REG_DRAW_HEIGHT = 3'd3,
    REG_TEX_WIDTH   = 3'd4,
    REG_TEX_HEIGHT  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        cmd;
    logic [11:0] texel_index;
    logic [31:0] texel_rgba;
    logic [11:0] offset_x;
    logic [11:0] offset_y;
    logic [31:0] dest_pixel;
  } in_beat_t;

  typedef struct packed {
    logic [16:0] pixel_index;
    logic [31:0] new_pixel;
  } out_beat_t;

  // Item state travelling alongside the datapath.
  typedef struct packed {
    logic        valid;
    logic        draw;
    logic        ok;
    logic        tzero;
    logic [16:0] pidx;
    logic [31:0] dst;
    logic [11:0] tidx;
    logic [31:0] trgba;
  } side_t;

endpackage

@@ hw/rtl/sab_div_pipe.sv @@
// ----------------------------------------------------------------------------
// sab_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sab_div_pipe
  import sab_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [NUMW-1:0] num,
  input  logic [11:0]     den,
  output logic [QW-1:0]   quo
);

  logic [NUMW-1:0] rem [QW];
  logic [QW-1:0]   qq  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int B = QW - 1 - i;
    logic [NUMW-1:0] rin;
    logic [QW-1:0]   qin;
    logic [NUMW-1:0] dsh;
    if (i == 0) begin : g_first
      assign rin = num;
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem[i-1];
      assign qin = qq[i-1];
    end
    assign dsh = NUMW'(den) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= dsh) begin
          rem[i] <= rin - dsh;
          qq[i]  <= qin | (QW'(1) << B);
        end else begin
          rem[i] <= rin;
          qq[i]  <= qin;
        end
      end
    end
  end

  assign quo = qq[QW-1];

endmodule

@@ hw/rtl/sab_texel_mem.sv @@
// ----------------------------------------------------------------------------
// sab_texel_mem
// Texel store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sab_texel_mem #(
  parameter int DEPTH = 4096
) (
  input  logic        clk,
  input  logic        en,
  input  logic        we,
  input  logic [11:0] waddr,
  input  logic [31:0] wdata,
  input  logic [sab_pkg::TAW-1:0] raddr,
  output logic [31:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[AW'(waddr)] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[AW'(raddr)];
    end
  end

endmodule

@@ hw/rtl/sab_blend.sv @@
// ----------------------------------------------------------------------------
// sab_blend
// Two-stage per-channel alpha blend of a texel over a canvas pixel.
// ----------------------------------------------------------------------------
module sab_blend
  import sab_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] texel,
  input  logic [31:0] dst,
  output logic [31:0] result
);

  logic [16:0] sum [3];
  logic [7:0]  src [3];
  logic [7:0]  alpha;
  logic [31:0] dst_d;

  // Stage 1: weighted sums with rounding bias.
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [7:0]  s;
    logic [7:0]  d;
    logic [7:0]  ia;
    assign s  = texel[31-8*c -: 8];
    assign d  = dst[23-8*c -: 8];
    assign ia = 8'd255 - texel[7:0];
    always_ff @(posedge clk) begin
      if (en) begin
        sum[c] <= 17'(16'(s) * 16'(texel[7:0])) + 17'(16'(d) * 16'(ia)) + 17'd127;
        src[c] <= s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha <= texel[7:0];
      dst_d <= dst;
    end
  end

  // Stage 2: divide by 255, pick by alpha.
  logic [7:0]  mixed [3];
  logic [31:0] result_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mixed[c] = 8'((sum[c] + (sum[c] >> 8) + 17'd1) >> 8);
    end
    if (alpha == ALPHA_FULL) begin
      result_next = OPAQUE | {8'h00, src[0], src[1], src[2]};
    end else if (alpha == ALPHA_NONE) begin
      result_next = dst_d;
    end else begin
      result_next = OPAQUE | {8'h00, mixed[0], mixed[1], mixed[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

@@ hw/rtl/scaled_alpha_blit.sv @@
// ----------------------------------------------------------------------------
// scaled_alpha_blit
// Nearest-neighbor scaled alpha-blend blitter with a local texel store.
// ----------------------------------------------------------------------------
//  channel  | handshake           | beat
//  ---------+---------------------+-------------------------------------
//  in       | in_valid / in_stall | in_beat_t: load texel or draw pixel
//  out      | out_valid/out_stall | out_beat_t: canvas address + pixel
//  cfg      | cfg_we              | cfg_index, cfg_data (write only)
//
// One beat enters per clock unless the output is stalled; a draw result passes the
// clip stage, 7 divider stages, address, texel read and two blend stages.
// The whole pipeline holds together when the output is stalled.
// Loads travel down the pipe and write the store at the read stage, so
// draws and loads see the store in their arrival order.
// Reset zeroes control state and origin, sets sizes to 1; store is not cleared.
// ----------------------------------------------------------------------------
module scaled_alpha_blit
  import sab_pkg::*;
#(
  parameter int CANVAS_W = CANVAS_W_DEF,
  parameter int CANVAS_H = CANVAS_H_DEF,
  parameter int TEX_SIDE = TEX_SIDE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_beat_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_beat_t       out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [CFGW-1:0] cfg_data
);

  localparam int DEPTH = TEX_SIDE * TEX_SIDE;
  localparam int NS    = QW;

  // Advance everything unless a finished beat is held at the output.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Configuration registers.
  logic [12:0] dest_x;
  logic [12:0] dest_y;
  logic [11:0] draw_width;
  logic [11:0] draw_height;
  logic [6:0]  tex_width;
  logic [6:0]  tex_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x      <= '0;
      dest_y      <= '0;
      draw_width  <= 12'd1;
      draw_height <= 12'd1;
      tex_width   <= 7'd1;
      tex_height  <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_X:      dest_x      <= cfg_data[12:0];
        REG_DEST_Y:      dest_y      <= cfg_data[12:0];
        REG_DRAW_WIDTH:  draw_width  <= cfg_data[11:0];
        REG_DRAW_HEIGHT: draw_height <= cfg_data[11:0];
        REG_TEX_WIDTH:   tex_width   <= cfg_data[6:0];
        REG_TEX_HEIGHT:  tex_height  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Stage A: clip, canvas position, divider numerators.
  logic signed [13:0] px_c;
  logic signed [13:0] py_c;
  logic               ok_c;
  side_t              a_side;
  logic [11:0]        a_px;
  logic [11:0]        a_py;
  logic [NUMW-1:0]    a_nx;
  logic [NUMW-1:0]    a_ny;

  always_comb begin
    px_c = $signed({dest_x[12], dest_x}) + $signed({2'b00, in_data.offset_x});
    py_c = $signed({dest_y[12], dest_y}) + $signed({2'b00, in_data.offset_y});
    ok_c = (draw_width != '0) && (draw_height != '0) &&
           (tex_width != '0) && (tex_height != '0) &&
           (in_data.offset_x < draw_width) && (in_data.offset_y < draw_height) &&
           (px_c >= 14'sd0) && (px_c < $signed(14'(CANVAS_W))) &&
           (py_c >= 14'sd0) && (py_c < $signed(14'(CANVAS_H)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_side.valid <= 1'b0;
    end else if (en) begin
      a_side.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side.draw  <= (in_data.cmd == CMD_DRAW);
      a_side.ok    <= ok_c;
      a_side.tzero <= 1'b0;
      a_side.pidx  <= '0;
      a_side.dst   <= in_data.dest_pixel;
      a_side.tidx  <= in_data.texel_index;
      a_side.trgba <= in_data.texel_rgba;
      a_px         <= px_c[11:0];
      a_py         <= py_c[11:0];
      a_nx         <= NUMW'(in_data.offset_x) * NUMW'(tex_width);
      a_ny         <= NUMW'(in_data.offset_y) * NUMW'(tex_height);
    end
  end

  // Divider stages: texture coordinates.
  logic [QW-1:0] sx;
  logic [QW-1:0] sy;

  sab_div_pipe u_div_x (
    .clk (clk), .en (en), .num (a_nx), .den (draw_width), .quo (sx)
  );
  sab_div_pipe u_div_y (
    .clk (clk), .en (en), .num (a_ny), .den (draw_height), .quo (sy)
  );

  // Side data alongside the divider; canvas address computed on entry.
  side_t       s_side [NS];
  logic [24:0] pidx_full;
  assign pidx_full = 25'(a_py) * 25'(CANVAS_W) + 25'(a_px);

  for (genvar i = 0; i < NS; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        s_side[i].valid <= 1'b0;
      end else if (en) begin
        s_side[i].valid <= (i == 0) ? a_side.valid : s_side[(i == 0) ? 0 : i-1].valid;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (i == 0) begin
          s_side[i].draw  <= a_side.draw;
          s_side[i].ok    <= a_side.ok;
          s_side[i].tzero <= a_side.tzero;
          s_side[i].pidx  <= pidx_full[16:0];
          s_side[i].dst   <= a_side.dst;
          s_side[i].tidx  <= a_side.tidx;
          s_side[i].trgba <= a_side.trgba;
        end else begin
          s_side[i].draw  <= s_side[(i == 0) ? 0 : i-1].draw;
          s_side[i].ok    <= s_side[(i == 0) ? 0 : i-1].ok;
          s_side[i].tzero <= s_side[(i == 0) ? 0 : i-1].tzero;
          s_side[i].pidx  <= s_side[(i == 0) ? 0 : i-1].pidx;
          s_side[i].dst   <= s_side[(i == 0) ? 0 : i-1].dst;
          s_side[i].tidx  <= s_side[(i == 0) ? 0 : i-1].tidx;
          s_side[i].trgba <= s_side[(i == 0) ? 0 : i-1].trgba;
        end
      end
    end
  end

  // Stage B: texel address.
  side_t          b_side;
  logic [TAW-1:0] b_addr;
  logic [TAW-1:0] addr_c;
  assign addr_c = TAW'(sy) * TAW'(tex_width) + TAW'(sx);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_side.valid <= 1'b0;
    end else if (en) begin
      b_side.valid <= s_side[NS-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side.draw  <= s_side[NS-1].draw;
      b_side.ok    <= s_side[NS-1].ok;
      b_side.tzero <= (25'(addr_c) >= 25'(DEPTH));
      b_side.pidx  <= s_side[NS-1].pidx;
      b_side.dst   <= s_side[NS-1].dst;
      b_side.tidx  <= s_side[NS-1].tidx;
      b_side.trgba <= s_side[NS-1].trgba;
      b_addr       <= addr_c;
    end
  end

  // Stage C: texel read; loads write here, in item order.
  logic        mem_we;
  logic [31:0] rdata;
  side_t       c_side;

  assign mem_we = b_side.valid && !b_side.draw && (25'(b_side.tidx) < 25'(DEPTH));

  sab_texel_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .en    (en),
    .we    (mem_we),
    .waddr (b_side.tidx),
    .wdata (b_side.trgba),
    .raddr (b_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_side.valid <= 1'b0;
    end else if (en) begin
      c_side.valid <= b_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side.draw  <= b_side.draw;
      c_side.ok    <= b_side.ok;
      c_side.tzero <= b_side.tzero;
      c_side.pidx  <= b_side.pidx;
      c_side.dst   <= b_side.dst;
      c_side.tidx  <= b_side.tidx;
      c_side.trgba <= b_side.trgba;
    end
  end

  // Stages D and output: blend.
  logic [31:0] texel;
  logic [31:0] blended;
  assign texel = c_side.tzero ? 32'd0 : rdata;

  sab_blend u_blend (
    .clk    (clk),
    .en     (en),
    .texel  (texel),
    .dst    (c_side.dst),
    .result (blended)
  );

  logic        d_keep;
  logic [16:0] d_pidx;
  logic [16:0] o_pidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_keep    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      d_keep    <= c_side.valid && c_side.draw && c_side.ok;
      out_valid <= d_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_pidx <= c_side.pidx;
      o_pidx <= d_pidx;
    end
  end

  assign out_data.pixel_index = o_pidx;
  assign out_data.new_pixel   = blended;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for scaled_alpha_blit: texel loads and draw beats
// with random idling on both sides, checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
module testbench;
  import sab_pkg::*;

  localparam int CW = CANVAS_W_DEF;
  localparam int CH = CANVAS_H_DEF;
  localparam int TS = TEX_SIDE_DEF;
  localparam int STORE_WORDS = TS * TS;
  localparam int FILL_WORDS = 256;   // 16 x 16 texels reachable by the draws
  localparam int PIPE_DRAIN = 40;
  localparam longint CYCLE_LIMIT = 600000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic            cfg_we = 1'b0;
  logic [2:0]      cfg_index = '0;
  logic [CFGW-1:0] cfg_data = '0;

  scaled_alpha_blit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: its own copy of the registers and the texel store.
  logic signed [12:0] box_x, box_y;
  logic [11:0] box_w, box_h;
  logic [6:0]  tex_w, tex_h;
  logic [31:0] texels [STORE_WORDS];

  in_beat_t  pending_beats [$];
  out_beat_t blended_pixels [$];
  int  errors = 0;
  longint cycles = 0;
  int  hold_off = 0;   // forced long receiver stall, set by stimulus

  function automatic logic [7:0] mix(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    int unsigned t;
    t = (s * a + d * (255 - a) + 127) / 255;
    return t[7:0];
  endfunction

  // Apply a load to the store copy, or blend a draw and queue its write if visible.
  task automatic predict_beat(in_beat_t b);
    int px, py;
    int unsigned sx, sy, addr;
    logic [31:0] tx, d, np;
    out_beat_t r;
    if (b.cmd == CMD_LOAD) begin
      if (b.texel_index < STORE_WORDS) begin
        texels[b.texel_index] = b.texel_rgba;
      end
      return;
    end
    if (box_w == 0 || box_h == 0 || tex_w == 0 || tex_h == 0) return;
    if (b.offset_x >= box_w || b.offset_y >= box_h) return;
    px = int'(box_x) + int'(b.offset_x);
    py = int'(box_y) + int'(b.offset_y);
    if (px < 0 || px >= CW || py < 0 || py >= CH) return;
    sx = b.offset_x * tex_w / box_w;
    sy = b.offset_y * tex_h / box_h;
    addr = sy * tex_w + sx;
    tx = (addr < STORE_WORDS) ? texels[addr] : 32'h0;
    d = b.dest_pixel;
    if (tx[7:0] == ALPHA_FULL) np = OPAQUE | {8'h00, tx[31:8]};
    else if (tx[7:0] == ALPHA_NONE) np = d;
    else np = OPAQUE | {8'h00, mix(tx[31:24], d[23:16], tx[7:0]),
                        mix(tx[23:16], d[15:8], tx[7:0]), mix(tx[15:8], d[7:0], tx[7:0])};
    r.pixel_index = 17'(py * CW + px);
    r.new_pixel = np;
    blended_pixels.push_back(r);
  endtask

  // Driver: present queued beats, hold while stalled, insert random gaps.
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_beat(in_data);
        void'(pending_beats.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if ((in_valid && !in_stall ? pending_beats.size() : pending_beats.size()) > 0)
        begin
          in_valid <= 1'b1;
          in_data <= pending_beats[0];
          if ($urandom_range(0, 9) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  int stall_left = 0;
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (blended_pixels.size() == 0) begin
          $error("result with no expectation: %h", out_data);
          errors++;
        end else begin
          e = blended_pixels.pop_front();
          if (out_data.pixel_index !== e.pixel_index) begin
            $error("pixel_index expected %h actual %h", e.pixel_index, out_data.pixel_index);
            errors++;
          end
          if (out_data.new_pixel !== e.new_pixel) begin
            $error("new_pixel expected %h actual %h", e.new_pixel, out_data.new_pixel);
            errors++;
          end
        end
      end
      // Receiver idling: long forced hold-off, else random stalls.
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (cycles % 2000 < 300) begin
        out_stall <= 1'b0;   // stretch with no receiver idling
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("scaled_alpha_blit regression: fail");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFGW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEST_X:      box_x = 13'(value);
      REG_DEST_Y:      box_y = 13'(value);
      REG_DRAW_WIDTH:  box_w = 12'(value);
      REG_DRAW_HEIGHT: box_h = 12'(value);
      REG_TEX_WIDTH:   tex_w = 7'(value);
      REG_TEX_HEIGHT:  tex_h = 7'(value);
      default: ;
    endcase
  endtask

  // Wait until every queued beat is in and every result is out, then drain.
  task automatic settle();
    wait (pending_beats.size() == 0 && !in_valid && blended_pixels.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk);
    wait (blended_pixels.size() == 0);
  endtask

  task automatic setup(int x, int y, int w, int h, int tw, int th);
    write_reg(REG_DEST_X, x);
    write_reg(REG_DEST_Y, y);
    write_reg(REG_DRAW_WIDTH, w);
    write_reg(REG_DRAW_HEIGHT, h);
    write_reg(REG_TEX_WIDTH, tw);
    write_reg(REG_TEX_HEIGHT, th);
  endtask

  function automatic in_beat_t load_beat(int idx, logic [31:0] rgba);
    in_beat_t b;
    b = '0;
    b.cmd = CMD_LOAD;
    b.texel_index = 12'(idx);
    b.texel_rgba = rgba;
    b.offset_x = 12'($urandom);
    b.offset_y = 12'($urandom);
    b.dest_pixel = $urandom;
    return b;
  endfunction

  function automatic in_beat_t draw_beat(int ox, int oy, logic [31:0] d);
    in_beat_t b;
    b.cmd = CMD_DRAW;
    b.texel_index = 12'($urandom);
    b.texel_rgba = $urandom;
    b.offset_x = 12'(ox);
    b.offset_y = 12'(oy);
    b.dest_pixel = d;
    return b;
  endfunction

  // Random texel with alpha leaning toward the two shortcut values.
  function automatic logic [31:0] rand_texel();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(0, 3))
      0: t[7:0] = ALPHA_FULL;
      1: t[7:0] = ALPHA_NONE;
      default: ;
    endcase
    return t;
  endfunction

  // Fill the part of the store that draws can reach (textures up to 16 x 16),
  // so no draw reads an unwritten texel.
  task automatic fill_store();
    for (int i = 0; i < FILL_WORDS; i++)
      pending_beats.push_back(load_beat(i, rand_texel()));
  endtask

  initial begin
    int ox, oy, w, h, n;
    box_x = 0; box_y = 0; box_w = 1; box_h = 1; tex_w = 1; tex_h = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset geometry, shortcut alphas, field extremes, clipping.
    pending_beats.push_back(load_beat(0, 32'hffffffff));
    pending_beats.push_back(draw_beat(0, 0, 32'h00000000));
    pending_beats.push_back(load_beat(0, 32'h12345600));
    pending_beats.push_back(draw_beat(0, 0, 32'hffffffff));
    pending_beats.push_back(load_beat(0, 32'h00ff7f80));
    pending_beats.push_back(draw_beat(0, 0, 32'h80ff0001));
    pending_beats.push_back(draw_beat(1, 0, 32'h5a5a5a5a));     // beyond box
    pending_beats.push_back(draw_beat(4094, 4094, 32'ha5a5a5a5));
    pending_beats.push_back(load_beat(4095, 32'h01020301));
    settle();
    fill_store();
    settle();
    setup(-4096, -4096, 4095, 4095, 64, 64);                     // off canvas
    pending_beats.push_back(draw_beat(4094, 4094, 32'h0));
    pending_beats.push_back(draw_beat(4095, 4095, 32'h0));
    settle();
    setup(4095, 4095, 1, 1, 1, 1);
    pending_beats.push_back(draw_beat(0, 0, 32'h0));
    settle();
    setup(CW - 1, CH - 1, 1, 1, 64, 64);                          // last pixel
    pending_beats.push_back(draw_beat(0, 0, 32'h11223344));
    settle();
    setup(-5, -3, 200, 100, 127, 127);                           // texel beyond store
    for (int i = 0; i < 6; i++) pending_beats.push_back(draw_beat(199 - i, 99 - i, $urandom));
    settle();
    setup(0, 0, 0, 5, 4, 4);                                     // zero draw size
    pending_beats.push_back(draw_beat(0, 0, 32'h1));
    settle();
    setup(0, 0, 5, 5, 0, 4);                                     // zero texture size
    pending_beats.push_back(draw_beat(0, 0, 32'h1));
    settle();

    // Back-pressure: receiver holds off while the sender keeps offering.
    setup(0, 0, 64, 64, 16, 16);
    hold_off = 200;
    for (int i = 0; i < 60; i++) pending_beats.push_back(draw_beat(i, i, $urandom));
    settle();

    // Random phases: mostly visible draws interleaved with reloads.
    for (int ph = 0; ph < 6; ph++) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 320);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 240);
      setup($urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) - 4096
                                      : $urandom_range(0, 340) - 20,
            $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) - 4096
                                      : $urandom_range(0, 260) - 20,
            w, h, $urandom_range(1, 16), $urandom_range(1, 16));
      n = 0;
      while (n < 100) begin
        if ($urandom_range(0, 5) == 0) begin
          pending_beats.push_back(load_beat($urandom_range(0, FILL_WORDS - 1), rand_texel()));
        end else begin
          ox = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4094) : $urandom_range(0, w - 1);
          oy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4094) : $urandom_range(0, h - 1);
          pending_beats.push_back(draw_beat(ox, oy, $urandom));
          n++;
        end
      end
      settle();
    end

    settle();
    if (errors == 0) begin
      $display("scaled_alpha_blit regression: pass");
    end else begin
      $display("scaled_alpha_blit regression: fail");
    end
    $finish;
  end
endmodule
